FILE: sv/mbe_pkg.sv
// Package for the Mandelbrot escape-time core: widths, image constants,
// register indexes, controller/datapath command types and saturation helper.
// No dependencies.
package mbe_pkg;

  // Image geometry and iteration cap
  localparam int IMAGE_WIDTH  = 1024;
  localparam int IMAGE_HEIGHT = 1024;
  localparam int ITER_LIMIT   = 1024;

  // Field widths
  localparam int COORD_W   = 10;
  localparam int ITER_W    = 11;
  localparam int Q_W       = 32;            // signed Q4.28
  localparam int STEP_W    = 31;            // unsigned Q3.28
  localparam int Q_FRAC    = 28;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  // Pixel offset from image center, and its product with a step
  localparam int OFF_W  = 14;
  localparam int PROD_W = OFF_W + STEP_W + 1;
  localparam int SQ_W   = 2 * Q_W;          // exact Q8.56 products
  localparam int SAT_W  = 48;               // input width of the saturator

  localparam logic [ITER_W-1:0] LIMIT_CAP = ITER_W'(ITER_LIMIT);
  localparam logic [SQ_W-1:0]   ESC_BOUND = SQ_W'(1) << (2 * Q_FRAC + 2);

  // Reset values of the configuration registers
  localparam logic signed [Q_W-1:0] CENTER_RE_RST = -32'sd134217728;
  localparam logic signed [Q_W-1:0] CENTER_IM_RST = 32'sd0;
  localparam logic [STEP_W-1:0]     STEP_RE_RST   = 31'd786432;
  localparam logic [STEP_W-1:0]     STEP_IM_RST   = 31'd524288;
  localparam logic [ITER_W-1:0]     MAX_ITER_RST  = 11'd256;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_RE = 3'd0,
    REG_CENTER_IM = 3'd1,
    REG_STEP_RE   = 3'd2,
    REG_STEP_IM   = 3'd3,
    REG_MAX_ITER  = 3'd4
  } cfg_reg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the pixel coordinate
    logic map_mul;   // offset times step
    logic map_sum;   // add center, saturate, clear z
    logic z_mul;     // square and cross products of z
    logic z_upd;     // form the next z
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic escape;    // |z|^2 of the current z exceeds 4
  } dp_stat_t;

  // Clamp a wide signed value to the signed Q4.28 range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(2147483647);
    lo = -(SAT_W'(2147483647)) - SAT_W'(1);
    if (v > hi) begin
      return {1'b0, {(Q_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(Q_W-1){1'b0}}};
    end
    return v[Q_W-1:0];
  endfunction

endpackage

FILE: sv/mbe_dp.sv
// Datapath of the Mandelbrot escape-time core: coordinate mapping, z
// registers, the product stage and the update/escape logic. Uses mbe_pkg.
module mbe_dp import mbe_pkg::*; (
  input  logic                     clk,
  input  dp_cmd_t                  cmd,
  input  logic [COORD_W-1:0]       pixel_x,
  input  logic [COORD_W-1:0]       pixel_y,
  input  logic signed [Q_W-1:0]    center_re,
  input  logic signed [Q_W-1:0]    center_im,
  input  logic [STEP_W-1:0]        step_re,
  input  logic [STEP_W-1:0]        step_im,
  output dp_stat_t                 stat,
  output logic [COORD_W-1:0]       px,
  output logic [COORD_W-1:0]       py
);

  logic signed [OFF_W-1:0]  off_x;
  logic signed [OFF_W-1:0]  off_y;
  logic signed [PROD_W-1:0] prod_re;
  logic signed [PROD_W-1:0] prod_im;
  logic signed [Q_W-1:0]    cr;
  logic signed [Q_W-1:0]    ci;
  logic signed [Q_W-1:0]    zr;
  logic signed [Q_W-1:0]    zi;
  logic signed [SQ_W-1:0]   rr;
  logic signed [SQ_W-1:0]   ii;
  logic signed [SQ_W-1:0]   ri;
  logic signed [SQ_W:0]     diff;
  logic signed [SAT_W-1:0]  map_re;
  logic signed [SAT_W-1:0]  map_im;
  logic signed [SAT_W-1:0]  upd_re;
  logic signed [SAT_W-1:0]  upd_im;
  logic [SQ_W-1:0]          mag;

  // Offset of the pixel from the image center
  assign off_x = $signed({{(OFF_W-COORD_W){1'b0}}, px}) - OFF_W'(IMAGE_WIDTH / 2);
  assign off_y = $signed({{(OFF_W-COORD_W){1'b0}}, py}) - OFF_W'(IMAGE_HEIGHT / 2);

  // Center plus scaled offset, before saturation
  assign map_re = SAT_W'(prod_re) + SAT_W'(center_re);
  assign map_im = SAT_W'(prod_im) + SAT_W'(center_im);

  // Next z: floor shifts of the exact products, plus c
  assign diff   = (SQ_W+1)'(rr) - (SQ_W+1)'(ii);
  assign upd_re = SAT_W'($signed(diff[SQ_W:Q_FRAC])) + SAT_W'(cr);
  assign upd_im = SAT_W'($signed(ri[SQ_W-1:Q_FRAC-1])) + SAT_W'(ci);

  // Escape test on the squares of the current z
  assign mag         = rr + ii;
  assign stat.escape = mag > ESC_BOUND;

  // Hold coordinate, c, z and products
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px <= pixel_x;
      py <= pixel_y;
    end
    if (cmd.map_mul) begin
      prod_re <= off_x * $signed({1'b0, step_re});
      prod_im <= off_y * $signed({1'b0, step_im});
    end
    if (cmd.map_sum) begin
      cr <= sat_q(map_re);
      ci <= sat_q(map_im);
      zr <= '0;
      zi <= '0;
    end
    if (cmd.z_mul) begin
      rr <= zr * zr;
      ii <= zi * zi;
      ri <= zr * zi;
    end
    if (cmd.z_upd) begin
      zr <= sat_q(upd_re);
      zi <= sat_q(upd_im);
    end
  end

endmodule

FILE: sv/mbe_ctrl.sv
// Controller of the Mandelbrot escape-time core: sequences mapping and the
// iteration loop, counts iterations and forms the result. Uses mbe_pkg.
module mbe_ctrl import mbe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ITER_W-1:0]  max_iter,
  input  dp_stat_t           stat,
  output dp_cmd_t            cmd,
  input  logic               out_free,
  output logic               load,
  output logic [ITER_W-1:0]  res_iter,
  output logic               res_esc
);

  typedef enum logic [2:0] {
    IDLE,
    MAP_MUL,
    MAP_SUM,
    Z_MUL,
    Z_UPD,
    FIN
  } state_t;

  state_t            state;
  logic [ITER_W-1:0] cnt;
  logic [ITER_W-1:0] limit;
  logic [ITER_W-1:0] limit_next;

  assign limit_next = (max_iter > LIMIT_CAP) ? LIMIT_CAP : max_iter;

  // Decode commands from the state
  always_comb begin
    cmd         = '0;
    in_ready    = (state == IDLE);
    load        = (state == FIN) && out_free;
    cmd.capture = in_ready && in_valid;
    cmd.map_mul = (state == MAP_MUL);
    cmd.map_sum = (state == MAP_SUM);
    cmd.z_mul   = (state == Z_MUL);
    cmd.z_upd   = (state == Z_UPD) && !stat.escape && (cnt != limit);
  end

  // Advance the sequence; cnt counts z updates done
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
      limit <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            limit <= limit_next;
            state <= MAP_MUL;
          end
        end
        MAP_MUL: begin
          state <= MAP_SUM;
        end
        MAP_SUM: begin
          cnt   <= '0;
          state <= Z_MUL;
        end
        Z_MUL: begin
          state <= Z_UPD;
        end
        Z_UPD: begin
          if (stat.escape) begin
            res_iter <= cnt - ITER_W'(1);
            res_esc  <= 1'b1;
            state    <= FIN;
          end else if (cnt == limit) begin
            res_iter <= cnt;
            res_esc  <= 1'b0;
            state    <= FIN;
          end else begin
            cnt   <= cnt + ITER_W'(1);
            state <= Z_MUL;
          end
        end
        FIN: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // The count never runs past the limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == Z_UPD) |-> (cnt <= limit))
    else $error("iteration count beyond limit");

  // A finished result stays within the limit
  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    (state == FIN) |-> (res_iter <= limit))
    else $error("result count beyond limit");

  // An escaped point escaped strictly before the limit
  a_esc_below: assert property (@(posedge clk) disable iff (rst)
    (state == FIN && res_esc) |-> (res_iter < limit))
    else $error("escape reported at the limit");

endmodule

FILE: sv/mandelbrot_escape_time_core.sv
// Top level of the Mandelbrot escape-time core: configuration registers,
// output register and the controller/datapath pair. Uses mbe_pkg, mbe_ctrl, mbe_dp.
//
// One pixel is processed at a time. After a beat is taken on the input, the
// coordinate is mapped to c in the MAP_MUL and MAP_SUM states, then each
// iteration of z = z*z + c passes Z_MUL, for the three 32x32 products of z,
// and Z_UPD, for the update and the escape test. The result beat sits in an
// output register; the next pixel is accepted while it waits to be taken.
module mandelbrot_escape_time_core import mbe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_W-1:0]     pixel_x,
  input  logic [COORD_W-1:0]     pixel_y,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ITER_W-1:0]      iter_count,
  output logic                   escaped,
  output logic [COORD_W-1:0]     out_x,
  output logic [COORD_W-1:0]     out_y,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  logic signed [Q_W-1:0] center_re;
  logic signed [Q_W-1:0] center_im;
  logic [STEP_W-1:0]     step_re;
  logic [STEP_W-1:0]     step_im;
  logic [ITER_W-1:0]     max_iter;
  dp_cmd_t               cmd;
  dp_stat_t              stat;
  logic                  load;
  logic                  out_free;
  logic [ITER_W-1:0]     res_iter;
  logic                  res_esc;
  logic [COORD_W-1:0]    px;
  logic [COORD_W-1:0]    py;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_re <= CENTER_RE_RST;
      center_im <= CENTER_IM_RST;
      step_re   <= STEP_RE_RST;
      step_im   <= STEP_IM_RST;
      max_iter  <= MAX_ITER_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_RE: center_re <= cfg_data[Q_W-1:0];
        REG_CENTER_IM: center_im <= cfg_data[Q_W-1:0];
        REG_STEP_RE:   step_re   <= cfg_data[STEP_W-1:0];
        REG_STEP_IM:   step_im   <= cfg_data[STEP_W-1:0];
        REG_MAX_ITER:  max_iter  <= cfg_data[ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .max_iter (max_iter),
    .stat     (stat),
    .cmd      (cmd),
    .out_free (out_free),
    .load     (load),
    .res_iter (res_iter),
    .res_esc  (res_esc)
  );

  mbe_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .center_re (center_re),
    .center_im (center_im),
    .step_re   (step_re),
    .step_im   (step_im),
    .stat      (stat),
    .px        (px),
    .py        (py)
  );

  // Output register: load a finished result, drop it once taken
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      iter_count <= res_iter;
      escaped    <= res_esc;
      out_x      <= px;
      out_y      <= py;
    end
  end

  // After a pixel is taken the core is busy with it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a pixel is in flight");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for mandelbrot_escape_time_core: drives pixel and result
// beats with random idling and checks each result against a fixed-point predictor.
// Depends on mbe_pkg and the core RTL.
module tb_top;
  import mbe_pkg::*;

  localparam int QUIET_LIMIT     = 20000;
  localparam int HOLD_CYCLES     = 3000;
  localparam int VIEWS_PER_PHASE = 4;
  localparam int PIXELS_PER_VIEW = 48;

  typedef struct packed {
    logic [ITER_W-1:0]  iters;
    logic               esc;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pixel_result_t;

  // Predict escape counts from its own copy of the view registers
  class escape_scoreboard;
    pixel_result_t        expected_q[$];
    logic signed [Q_W-1:0] c_re;
    logic signed [Q_W-1:0] c_im;
    logic [STEP_W-1:0]    s_re;
    logic [STEP_W-1:0]    s_im;
    logic [ITER_W-1:0]    limit_reg;
    int                   errors;
    int                   escapes;
    int                   captives;

    function new();
      c_re      = CENTER_RE_RST;
      c_im      = CENTER_IM_RST;
      s_re      = STEP_RE_RST;
      s_im      = STEP_IM_RST;
      limit_reg = MAX_ITER_RST;
      errors    = 0;
      escapes   = 0;
      captives  = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_CENTER_RE: c_re = val;
        REG_CENTER_IM: c_im = val;
        REG_STEP_RE:   s_re = val[STEP_W-1:0];
        REG_STEP_IM:   s_im = val[STEP_W-1:0];
        REG_MAX_ITER:  limit_reg = val[ITER_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_q(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function pixel_result_t escape_time(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      pixel_result_t r;
      longint        cr;
      longint        ci;
      longint        zr;
      longint        zi;
      longint        rr;
      longint        ii;
      longint        ri;
      logic [63:0]   mag;
      int            lim;
      int            n;
      bit            esc;
      // map the pixel to c, saturating the sum with the center
      cr = clamp_q(longint'(c_re) +
                   (longint'({54'd0, x}) - IMAGE_WIDTH / 2) * longint'({33'd0, s_re}));
      ci = clamp_q(longint'(c_im) +
                   (longint'({54'd0, y}) - IMAGE_HEIGHT / 2) * longint'({33'd0, s_im}));
      lim = (limit_reg > LIMIT_CAP) ? int'(LIMIT_CAP) : int'(limit_reg);
      zr  = 0;
      zi  = 0;
      n   = 0;
      esc = 1'b0;
      // iterate z = z*z + c with floor reduction and saturation
      while (n < lim && !esc) begin
        rr  = zr * zr;
        ii  = zi * zi;
        ri  = zr * zi;
        zr  = clamp_q(((rr - ii) >>> Q_FRAC) + cr);
        zi  = clamp_q((ri >>> (Q_FRAC - 1)) + ci);
        mag = $unsigned(zr * zr) + $unsigned(zi * zi);
        if (mag > ESC_BOUND) esc = 1'b1;
        else n++;
      end
      r.iters = ITER_W'(n);
      r.esc   = esc;
      r.x     = x;
      r.y     = y;
      return r;
    endfunction

    function void note_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      expected_q.push_back(escape_time(x, y));
    endfunction

    function void check_result(logic [ITER_W-1:0] iters, logic esc,
                               logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      pixel_result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no pixel outstanding (out_x %0d, out_y %0d)", x, y);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (iters !== want.iters) begin
        $error("iter_count: expected %0d, actual %0d", want.iters, iters);
        errors++;
      end
      if (esc !== want.esc) begin
        $error("escaped: expected %0d, actual %0d", want.esc, esc);
        errors++;
      end
      if (x !== want.x) begin
        $error("out_x: expected %0d, actual %0d", want.x, x);
        errors++;
      end
      if (y !== want.y) begin
        $error("out_y: expected %0d, actual %0d", want.y, y);
        errors++;
      end
      if (want.esc) escapes++;
      else captives++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [COORD_W-1:0] pixel_x = '0;
  logic [COORD_W-1:0] pixel_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ITER_W-1:0]  iter_count;
  logic               escaped;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  escape_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int views = 0;

  mandelbrot_escape_time_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .iter_count (iter_count),
    .escaped    (escaped),
    .out_x      (out_x),
    .out_y      (out_y),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Drive result ready: random stalls, plus a long hold-off on request
  initial begin
    int holds_done;
    int hold_left;
    holds_done = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Record accepted beats and watch for a stalled run
  always @(posedge clk) begin
    int quiet_cycles;
    if (!rst) begin
      if (in_valid && in_ready) sb.note_pixel(pixel_x, pixel_y);
      if (out_valid && out_ready) sb.check_result(iter_count, escaped, out_x, out_y);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no beat for %0d cycles, %0d results outstanding",
                 quiet_cycles, sb.pending());
        $display("[mandelbrot_escape_time_core] ERROR");
        $finish;
      end
    end
  end

  // Offer one pixel beat and hold it until taken
  task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_x  <= x;
    pixel_y  <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every pixel has come back
  task automatic finish_beats();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // Load a full view once the core has gone idle
  task automatic set_view(input logic [CFG_W-1:0] cre, input logic [CFG_W-1:0] cim,
                          input logic [CFG_W-1:0] sre, input logic [CFG_W-1:0] sim,
                          input logic [CFG_W-1:0] mi);
    finish_beats();
    write_reg(REG_CENTER_RE, cre);
    write_reg(REG_CENTER_IM, cim);
    write_reg(REG_STEP_RE, sre);
    write_reg(REG_STEP_IM, sim);
    write_reg(REG_MAX_ITER, mi);
    cfg_we <= 1'b0;
    views++;
  endtask

  // Mostly views around the set, sometimes anywhere in the Q4.28 range
  task automatic random_view();
    logic [CFG_W-1:0] cre;
    logic [CFG_W-1:0] cim;
    logic [CFG_W-1:0] sre;
    logic [CFG_W-1:0] sim;
    logic [CFG_W-1:0] mi;
    cre = ($urandom_range(99) < 75) ? $urandom_range(32'h3000_0000) - 32'h2000_0000
                                    : $urandom();
    cim = ($urandom_range(99) < 75) ? $urandom_range(32'h3000_0000) - 32'h1800_0000
                                    : $urandom();
    case ($urandom_range(9))
      0:       sre = $urandom() & 32'h7fff_ffff;
      1, 2:    sre = $urandom_range(32'h0001_0000);
      default: sre = $urandom_range(32'h0040_0000, 32'h0001_0000);
    endcase
    case ($urandom_range(9))
      0:       sim = $urandom() & 32'h7fff_ffff;
      1, 2:    sim = $urandom_range(32'h0001_0000);
      default: sim = $urandom_range(32'h0040_0000, 32'h0001_0000);
    endcase
    mi = ($urandom_range(99) < 85) ? $urandom_range(64, 1) : $urandom_range(512, 65);
    set_view(cre, cim, sre, sim, mi);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(19))
      0:       return '0;
      1:       return '1;
      2:       return COORD_W'(IMAGE_WIDTH / 2);
      3:       return COORD_W'(IMAGE_WIDTH / 2 - 1);
      default: return COORD_W'($urandom_range(1023));
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 51;

    // Reset view: corners, center (inside at the full limit) and interior points
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(0, 1023);
    send_pixel(1023, 0);
    send_pixel(512, 512);
    send_pixel(511, 512);
    send_pixel(256, 768);

    // Zero limit: no iteration at all
    set_view(32'hf800_0000, 32'h0, 32'd786432, 32'd524288, 32'd0);
    send_pixel(512, 512);
    send_pixel(0, 0);

    // Limit above the cap saturates to the cap
    set_view(32'hf800_0000, 32'h0, 32'd786432, 32'd524288, 32'd2047);
    send_pixel(512, 512);
    send_pixel(0, 0);

    // Single iteration
    set_view(32'hf800_0000, 32'h0, 32'd786432, 32'd524288, 32'd1);
    send_pixel(512, 512);
    send_pixel(1023, 0);

    // Extreme centers and steps: c saturates both ways
    set_view(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'd16);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(512, 512);
    set_view(32'h8000_0000, 32'h7fff_ffff, 32'd1, 32'd0, 32'd8);
    send_pixel(1023, 0);
    send_pixel(0, 1023);

    // Zero step: every pixel maps to c = 0 and never escapes
    set_view(32'h0, 32'h0, 32'd0, 32'd0, 32'd1024);
    send_pixel(123, 901);
    send_pixel(1023, 1023);

    // Random views under three idling regimes
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 51 : 0;
      recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 19 : 0;
      for (int v = 0; v < VIEWS_PER_PHASE; v++) begin
        random_view();
        // fill the core while results are held back
        if (phase == 2 && v == 0) hold_requests++;
        for (int k = 0; k < PIXELS_PER_VIEW; k++) send_pixel(pick_coord(), pick_coord());
      end
    end

    finish_beats();
    repeat (2 * ITER_LIMIT + 8) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end

    $display("%0d pixels checked over %0d views: %0d escaped, %0d ran to the limit",
             sb.escapes + sb.captives, views + 1, sb.escapes, sb.captives);
    $display("covered zero and saturated limits, saturated c, and a long output stall");
    if (sb.errors == 0) begin
      $display("[mandelbrot_escape_time_core] OK");
    end else begin
      $display("[mandelbrot_escape_time_core] ERROR");
    end
    $finish;
  end

endmodule
